// ===== rtl/dps_pkg.sv =====
// ----------------------------------------------------------------------------
// dps_pkg - detector power sequencer package
// State encodings, action codes, opcodes, register indexes, reset values and bias steps.
// ----------------------------------------------------------------------------
`default_nettype none

package dps_pkg;

    // Item opcodes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_READY  = 2'd1;
    localparam logic [1:0] OP_DIRECT = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_TARGET_TEMP  = 3'd0;
    localparam logic [2:0] CFG_STEP_DELAY   = 3'd1;
    localparam logic [2:0] CFG_RAIL_SETTLE  = 3'd2;
    localparam logic [2:0] CFG_BIAS_SETTLE  = 3'd3;
    localparam logic [2:0] CFG_COOLER_WAIT  = 3'd4;

    // Register reset values
    localparam logic [8:0]  TARGET_TEMP_RST = 9'd80;
    localparam logic [15:0] STEP_DELAY_RST  = 16'd100;
    localparam logic [15:0] RAIL_SETTLE_RST = 16'd2000;
    localparam logic [15:0] BIAS_SETTLE_RST = 16'd1000;
    localparam logic [15:0] COOLER_WAIT_RST = 16'd2000;

    // Detector actions
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_RAILS_ON = 3'd1;
    localparam logic [2:0] ACT_ACQ_ON   = 3'd2;
    localparam logic [2:0] ACT_SET_BIAS = 3'd3;
    localparam logic [2:0] ACT_ACQ_OFF  = 3'd4;
    localparam logic [2:0] ACT_RAILS_OFF = 3'd5;

    // Cooler actions
    localparam logic [1:0] COOL_NONE  = 2'd0;
    localparam logic [1:0] COOL_START = 2'd1;
    localparam logic [1:0] COOL_STOP  = 2'd2;

    // Bias steps in volts
    localparam logic [5:0] V_10 = 6'd10;
    localparam logic [5:0] V_30 = 6'd30;
    localparam logic [5:0] V_50 = 6'd50;
    localparam logic [5:0] V_55 = 6'd55;
    localparam logic [5:0] V_58 = 6'd58;

    typedef enum logic [4:0] {
        D_IDLE          = 5'd0,
        D_RAILS         = 5'd1,
        D_RAILS_WAIT    = 5'd2,
        D_UP30          = 5'd3,
        D_UP30_WAIT     = 5'd4,
        D_UP50          = 5'd5,
        D_UP50_WAIT     = 5'd6,
        D_UP55          = 5'd7,
        D_UP55_WAIT     = 5'd8,
        D_UP58          = 5'd9,
        D_UP58_WAIT     = 5'd10,
        D_UP_DONE       = 5'd11,
        D_DN50          = 5'd12,
        D_DN50_WAIT     = 5'd13,
        D_DN30          = 5'd14,
        D_DN30_WAIT     = 5'd15,
        D_DN10          = 5'd16,
        D_DN10_WAIT     = 5'd17,
        D_DN_FINAL_WAIT = 5'd18,
        D_DN_DONE       = 5'd19
    } det_state_t;

    typedef enum logic [3:0] {
        R_IDLE               = 4'd0,
        R_COOLING            = 4'd1,
        R_COOLING_WAIT       = 4'd2,
        R_DETECTOR           = 4'd3,
        R_DETECTOR_WAIT      = 4'd4,
        R_COMPLETE           = 4'd5,
        R_DET_SHUTDOWN       = 4'd6,
        R_DET_SHUTDOWN_WAIT  = 4'd7,
        R_COOL_SHUTDOWN      = 4'd8,
        R_COOL_SHUTDOWN_WAIT = 4'd9,
        R_INCOMPLETE         = 4'd10
    } rdy_state_t;

    // Which wait a detector stage uses
    typedef enum logic [1:0] {
        W_NONE = 2'd0,
        W_STEP = 2'd1,
        W_RAIL = 2'd2,
        W_BIAS = 2'd3
    } wait_sel_t;

endpackage

`default_nettype wire

// ===== rtl/detector_power_sequencer.sv =====
// ----------------------------------------------------------------------------
// detector_power_sequencer - detector bias and readiness sequencer
// Two linked millisecond-timed state machines: detector bias staging and
// cooler/detector readiness. One result item per input item.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: opcode; tdata: request, ok, temp
//  m_*       out  m_tvalid/m_tready  tdata: actions, bias, phases, flags
//  cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
//  An accepted item goes into the input register, then the sequencer update
//  writes the result register, unless a waiting result holds it. One item
//  per cycle sustained while m_tready stays high. A waiting result holds the
//  input register; once that is full, s_tready stays low until m_tready
//  returns. Reset puts both sequencers in idle, clears timers and the
//  reported bias and loads the register defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module detector_power_sequencer #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    input  wire logic [15:0] s_tdata,   // [0] request_bit, [1] cooler_ok,
                                        // [13:2] cooler_temp_dk, [15:14] zero
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [2:0] detector_action,
                                        // [8:3] bias_step_volts,
                                        // [14:9] bias_now_volts,
                                        // [16:15] cooler_action,
                                        // [21:17] detector_phase,
                                        // [25:22] readiness_phase,
                                        // [26] complete_flag, [27] powering_up,
                                        // [31:28] zero
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [8:0]  target_temp_reg;
    logic [15:0] step_delay_reg;
    logic [15:0] rail_settle_reg;
    logic [15:0] bias_settle_reg;
    logic [15:0] cooler_wait_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_temp_reg <= dps_pkg::TARGET_TEMP_RST;
            step_delay_reg  <= dps_pkg::STEP_DELAY_RST;
            rail_settle_reg <= dps_pkg::RAIL_SETTLE_RST;
            bias_settle_reg <= dps_pkg::BIAS_SETTLE_RST;
            cooler_wait_reg <= dps_pkg::COOLER_WAIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dps_pkg::CFG_TARGET_TEMP: target_temp_reg <= cfg_data[8:0];
                dps_pkg::CFG_STEP_DELAY:  step_delay_reg  <= cfg_data;
                dps_pkg::CFG_RAIL_SETTLE: rail_settle_reg <= cfg_data;
                dps_pkg::CFG_BIAS_SETTLE: bias_settle_reg <= cfg_data;
                dps_pkg::CFG_COOLER_WAIT: cooler_wait_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Input register
    logic [1:0]  op_reg;
    logic        req_reg;
    logic        ok_reg;
    logic [11:0] temp_reg;

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= s_tuser;
            req_reg  <= s_tdata[0];
            ok_reg   <= s_tdata[1];
            temp_reg <= s_tdata[13:2];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    dps_pkg::det_state_t     det_state_reg, det_state_next;
    dps_pkg::rdy_state_t     rdy_state_reg, rdy_state_next;
    logic [TIMER_BITS-1:0]   det_timer_reg, det_timer_next;
    logic [TIMER_BITS-1:0]   rdy_timer_reg, rdy_timer_next;
    logic [5:0]              bias_reg, bias_next;
    logic                    last_ready_reg, last_ready_next;
    logic                    last_direct_reg, last_direct_next;

    // Saturating timer bumps
    logic [TIMER_BITS-1:0] det_bump;
    logic [TIMER_BITS-1:0] rdy_bump;

    assign det_bump = (det_timer_reg == TIMER_MAX) ? det_timer_reg
                                                   : det_timer_reg + TIMER_BITS'(1);
    assign rdy_bump = (rdy_timer_reg == TIMER_MAX) ? rdy_timer_reg
                                                   : rdy_timer_reg + TIMER_BITS'(1);

    // Detector stage wait selection
    dps_pkg::wait_sel_t wait_sel;
    logic [15:0]        wait_ms;
    logic               det_fire;

    always_comb
    begin
        unique case (det_state_reg)
            dps_pkg::D_RAILS, dps_pkg::D_UP30, dps_pkg::D_UP50, dps_pkg::D_UP55,
            dps_pkg::D_UP58, dps_pkg::D_DN50, dps_pkg::D_DN30, dps_pkg::D_DN10:
                wait_sel = dps_pkg::W_STEP;
            dps_pkg::D_RAILS_WAIT:
                wait_sel = dps_pkg::W_RAIL;
            dps_pkg::D_UP30_WAIT, dps_pkg::D_UP50_WAIT, dps_pkg::D_UP55_WAIT,
            dps_pkg::D_UP58_WAIT, dps_pkg::D_DN50_WAIT, dps_pkg::D_DN30_WAIT,
            dps_pkg::D_DN10_WAIT, dps_pkg::D_DN_FINAL_WAIT:
                wait_sel = dps_pkg::W_BIAS;
            default:
                wait_sel = dps_pkg::W_NONE;
        endcase
    end

    always_comb
    begin
        case (wait_sel)
            dps_pkg::W_STEP: wait_ms = step_delay_reg;
            dps_pkg::W_RAIL: wait_ms = rail_settle_reg;
            default:         wait_ms = bias_settle_reg;
        endcase
    end

    assign det_fire = (wait_sel != dps_pkg::W_NONE)
                   && (CMP_W'(det_bump) >= CMP_W'(wait_ms));

    // Detector outputs on a firing stage: action, bias request, bias report
    logic [2:0] tick_act;
    logic [5:0] tick_volts;
    logic [5:0] tick_bias;

    always_comb
    begin
        tick_act   = dps_pkg::ACT_NONE;
        tick_volts = 6'd0;
        tick_bias  = bias_reg;
        if (det_fire)
        begin
            unique case (det_state_reg)
                dps_pkg::D_RAILS:      tick_act = dps_pkg::ACT_RAILS_ON;
                dps_pkg::D_RAILS_WAIT: tick_act = dps_pkg::ACT_ACQ_ON;
                dps_pkg::D_UP30, dps_pkg::D_DN30:
                begin
                    tick_act   = dps_pkg::ACT_SET_BIAS;
                    tick_volts = dps_pkg::V_30;
                end
                dps_pkg::D_UP50, dps_pkg::D_DN50:
                begin
                    tick_act   = dps_pkg::ACT_SET_BIAS;
                    tick_volts = dps_pkg::V_50;
                end
                dps_pkg::D_UP55:
                begin
                    tick_act   = dps_pkg::ACT_SET_BIAS;
                    tick_volts = dps_pkg::V_55;
                end
                dps_pkg::D_UP58:
                begin
                    tick_act   = dps_pkg::ACT_SET_BIAS;
                    tick_volts = dps_pkg::V_58;
                end
                dps_pkg::D_DN10:
                begin
                    tick_act   = dps_pkg::ACT_SET_BIAS;
                    tick_volts = dps_pkg::V_10;
                end
                dps_pkg::D_UP30_WAIT, dps_pkg::D_DN30_WAIT: tick_bias = dps_pkg::V_30;
                dps_pkg::D_UP50_WAIT, dps_pkg::D_DN50_WAIT: tick_bias = dps_pkg::V_50;
                dps_pkg::D_UP55_WAIT:  tick_bias = dps_pkg::V_55;
                dps_pkg::D_UP58_WAIT:  tick_bias = dps_pkg::V_58;
                dps_pkg::D_DN10_WAIT:
                begin
                    tick_bias = dps_pkg::V_10;
                    tick_act  = dps_pkg::ACT_ACQ_OFF;
                end
                dps_pkg::D_DN_FINAL_WAIT: tick_act = dps_pkg::ACT_RAILS_OFF;
                default: ;
            endcase
        end
    end

    // Detector next stage on a tick (before any readiness override)
    dps_pkg::det_state_t det_tick_state;

    always_comb
    begin
        det_tick_state = det_state_reg;
        if (det_fire)
        begin
            unique case (det_state_reg)
                dps_pkg::D_RAILS:         det_tick_state = dps_pkg::D_RAILS_WAIT;
                dps_pkg::D_RAILS_WAIT:    det_tick_state = dps_pkg::D_UP30;
                dps_pkg::D_UP30:          det_tick_state = dps_pkg::D_UP30_WAIT;
                dps_pkg::D_UP30_WAIT:     det_tick_state = dps_pkg::D_UP50;
                dps_pkg::D_UP50:          det_tick_state = dps_pkg::D_UP50_WAIT;
                dps_pkg::D_UP50_WAIT:     det_tick_state = dps_pkg::D_UP55;
                dps_pkg::D_UP55:          det_tick_state = dps_pkg::D_UP55_WAIT;
                dps_pkg::D_UP55_WAIT:     det_tick_state = dps_pkg::D_UP58;
                dps_pkg::D_UP58:          det_tick_state = dps_pkg::D_UP58_WAIT;
                dps_pkg::D_UP58_WAIT:     det_tick_state = dps_pkg::D_UP_DONE;
                dps_pkg::D_DN50:          det_tick_state = dps_pkg::D_DN50_WAIT;
                dps_pkg::D_DN50_WAIT:     det_tick_state = dps_pkg::D_DN30;
                dps_pkg::D_DN30:          det_tick_state = dps_pkg::D_DN30_WAIT;
                dps_pkg::D_DN30_WAIT:     det_tick_state = dps_pkg::D_DN10;
                dps_pkg::D_DN10:          det_tick_state = dps_pkg::D_DN10_WAIT;
                dps_pkg::D_DN10_WAIT:     det_tick_state = dps_pkg::D_DN_FINAL_WAIT;
                dps_pkg::D_DN_FINAL_WAIT: det_tick_state = dps_pkg::D_DN_DONE;
                default: ;
            endcase
        end
    end

    // Cooler temperature check: temp_dk <= 10 * target_k
    logic [12:0] target_dk;
    logic        temp_reached;

    assign target_dk    = {1'b0, target_temp_reg, 3'b000}
                        + {3'b000, target_temp_reg, 1'b0};
    assign temp_reached = {1'b0, temp_reg} <= target_dk;

    // Readiness outputs: cooler requests
    logic [1:0] tick_cool;

    always_comb
    begin
        unique case (rdy_state_reg)
            dps_pkg::R_COOLING:      tick_cool = dps_pkg::COOL_START;
            dps_pkg::R_COOL_SHUTDOWN: tick_cool = dps_pkg::COOL_STOP;
            default:                 tick_cool = dps_pkg::COOL_NONE;
        endcase
    end

    // Item update: tick runs detector then readiness; commands jump states
    always_comb
    begin
        det_state_next   = det_state_reg;
        det_timer_next   = det_timer_reg;
        rdy_state_next   = rdy_state_reg;
        rdy_timer_next   = rdy_timer_reg;
        bias_next        = bias_reg;
        last_ready_next  = last_ready_reg;
        last_direct_next = last_direct_reg;

        case (op_reg)
            dps_pkg::OP_TICK:
            begin
                det_state_next = det_tick_state;
                det_timer_next = det_fire ? '0 : det_bump;
                bias_next      = tick_bias;
                rdy_timer_next = rdy_bump;
                unique case (rdy_state_reg)
                    dps_pkg::R_COOLING:
                        if (ok_reg)
                            rdy_state_next = dps_pkg::R_COOLING_WAIT;
                    dps_pkg::R_COOLING_WAIT:
                        if (temp_reached)
                            rdy_state_next = dps_pkg::R_DETECTOR;
                    dps_pkg::R_DETECTOR:
                    begin
                        det_state_next = dps_pkg::D_RAILS;
                        det_timer_next = '0;
                        rdy_state_next = dps_pkg::R_DETECTOR_WAIT;
                    end
                    dps_pkg::R_DETECTOR_WAIT:
                        if (det_tick_state == dps_pkg::D_UP_DONE)
                            rdy_state_next = dps_pkg::R_COMPLETE;
                    dps_pkg::R_DET_SHUTDOWN:
                    begin
                        det_state_next = dps_pkg::D_DN50;
                        det_timer_next = '0;
                        rdy_state_next = dps_pkg::R_DET_SHUTDOWN_WAIT;
                    end
                    dps_pkg::R_DET_SHUTDOWN_WAIT:
                        if (det_tick_state == dps_pkg::D_DN_DONE)
                            rdy_state_next = dps_pkg::R_COOL_SHUTDOWN;
                    dps_pkg::R_COOL_SHUTDOWN:
                        if (ok_reg)
                        begin
                            rdy_state_next = dps_pkg::R_COOL_SHUTDOWN_WAIT;
                            rdy_timer_next = '0;
                        end
                    dps_pkg::R_COOL_SHUTDOWN_WAIT:
                        if (CMP_W'(rdy_bump) >= CMP_W'(cooler_wait_reg))
                            rdy_state_next = dps_pkg::R_INCOMPLETE;
                    default: ;
                endcase
            end
            dps_pkg::OP_READY:
            begin
                if (req_reg != last_ready_reg)
                begin
                    rdy_state_next  = req_reg ? dps_pkg::R_COOLING
                                              : dps_pkg::R_DET_SHUTDOWN;
                    last_ready_next = req_reg;
                end
            end
            dps_pkg::OP_DIRECT:
            begin
                if (req_reg != last_direct_reg)
                begin
                    det_state_next   = req_reg ? dps_pkg::D_RAILS : dps_pkg::D_DN50;
                    det_timer_next   = '0;
                    last_direct_next = req_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_state_reg   <= dps_pkg::D_IDLE;
            rdy_state_reg   <= dps_pkg::R_IDLE;
            det_timer_reg   <= '0;
            rdy_timer_reg   <= '0;
            bias_reg        <= 6'd0;
            last_ready_reg  <= 1'b0;
            last_direct_reg <= 1'b0;
        end
        else if (advance)
        begin
            det_state_reg   <= det_state_next;
            rdy_state_reg   <= rdy_state_next;
            det_timer_reg   <= det_timer_next;
            rdy_timer_reg   <= rdy_timer_next;
            bias_reg        <= bias_next;
            last_ready_reg  <= last_ready_next;
            last_direct_reg <= last_direct_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic        is_tick;
    logic [2:0]  res_act_reg;
    logic [5:0]  res_volts_reg;
    logic [5:0]  res_bias_reg;
    logic [1:0]  res_cool_reg;
    logic [4:0]  res_det_reg;
    logic [3:0]  res_rdy_reg;
    logic        res_done_reg;
    logic        res_up_reg;

    assign is_tick = (op_reg == dps_pkg::OP_TICK);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_act_reg   <= is_tick ? tick_act : dps_pkg::ACT_NONE;
            res_volts_reg <= is_tick ? tick_volts : 6'd0;
            res_bias_reg  <= bias_next;
            res_cool_reg  <= is_tick ? tick_cool : dps_pkg::COOL_NONE;
            res_det_reg   <= det_state_next;
            res_rdy_reg   <= rdy_state_next;
            res_done_reg  <= (rdy_state_next == dps_pkg::R_COMPLETE);
            res_up_reg    <= (det_state_next >= dps_pkg::D_RAILS)
                          && (det_state_next <= dps_pkg::D_UP58);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_up_reg, res_done_reg, res_rdy_reg, res_det_reg,
                       res_cool_reg, res_bias_reg, res_volts_reg, res_act_reg};

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb - detector power sequencer testbench
// Sends ticks and commands in bursts while the result side stalls on its own
// pattern. A behavioral model of both sequencers predicts each result item,
// and every accepted result is compared field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import dps_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RUN_LIMIT_NS = 2_000_000;

    // Opcode the block must ignore
    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [2:0] det_action;
        logic [5:0] step_volts;
        logic [5:0] bias_now;
        logic [1:0] cool_action;
        det_state_t det_phase;
        rdy_state_t rdy_phase;
        logic       complete;
        logic       powering_up;
    } seq_result_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser   = '0;   // [1:0] opcode
    logic [15:0] s_tdata   = '0;   // [0] request_bit, [1] cooler_ok,
                                   // [13:2] cooler_temp_dk, [15:14] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [2:0] detector_action, [8:3] bias_step_volts,
                                   // [14:9] bias_now_volts, [16:15] cooler_action,
                                   // [21:17] detector_phase, [25:22] readiness_phase,
                                   // [26] complete_flag, [27] powering_up
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // Predicted register contents
    logic [8:0]  cfg_target    = TARGET_TEMP_RST;
    logic [15:0] cfg_step      = STEP_DELAY_RST;
    logic [15:0] cfg_rail      = RAIL_SETTLE_RST;
    logic [15:0] cfg_settle    = BIAS_SETTLE_RST;
    logic [15:0] cfg_stop_wait = COOLER_WAIT_RST;

    // Predicted sequencer state
    det_state_t  pred_det        = D_IDLE;
    rdy_state_t  pred_rdy        = R_IDLE;
    logic [15:0] det_ms          = '0;
    logic [15:0] rdy_ms          = '0;
    logic [5:0]  bias_level      = '0;
    logic        ready_req_seen  = 1'b0;
    logic        direct_req_seen = 1'b0;

    seq_result_t expected_q[$];
    int          mismatches  = 0;
    int          burst_left  = 0;
    int          stall_left  = 0;
    int          stall_mode  = 0;

    detector_power_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------
    function automatic logic [15:0] ms_bump(logic [15:0] t);
        return (t == 16'hFFFF) ? t : t + 16'd1;
    endfunction

    function automatic void enter_det(det_state_t s);
        pred_det = s;
        det_ms   = '0;
    endfunction

    // Bias voltage belonging to a bias issue or bias settle stage
    function automatic logic [5:0] stage_volts(det_state_t s);
        case (s)
            D_UP30, D_UP30_WAIT, D_DN30, D_DN30_WAIT: return V_30;
            D_UP50, D_UP50_WAIT, D_DN50, D_DN50_WAIT: return V_50;
            D_UP55, D_UP55_WAIT:                      return V_55;
            D_UP58, D_UP58_WAIT:                      return V_58;
            default:                                  return V_10;
        endcase
    endfunction

    function automatic seq_result_t sequence_step(logic [1:0] op, logic req, logic ok,
                                                  logic [11:0] temp);
        seq_result_t r;
        logic [15:0] t;
        r = '0;
        if (op == OP_TICK)
        begin
            // detector sequencer acts first
            det_ms = ms_bump(det_ms);
            t = det_ms;
            case (pred_det)
                D_RAILS:
                    if (t >= cfg_step)
                    begin
                        r.det_action = ACT_RAILS_ON;
                        enter_det(D_RAILS_WAIT);
                    end
                D_RAILS_WAIT:
                    if (t >= cfg_rail)
                    begin
                        r.det_action = ACT_ACQ_ON;
                        enter_det(D_UP30);
                    end
                D_UP30, D_UP50, D_UP55, D_UP58, D_DN50, D_DN30, D_DN10:
                    if (t >= cfg_step)
                    begin
                        r.det_action = ACT_SET_BIAS;
                        r.step_volts = stage_volts(pred_det);
                        enter_det(det_state_t'(pred_det + 5'd1));
                    end
                D_UP30_WAIT, D_UP50_WAIT, D_UP55_WAIT, D_UP58_WAIT,
                D_DN50_WAIT, D_DN30_WAIT, D_DN10_WAIT:
                    if (t >= cfg_settle)
                    begin
                        bias_level = stage_volts(pred_det);
                        if (pred_det == D_DN10_WAIT)
                            r.det_action = ACT_ACQ_OFF;
                        enter_det(det_state_t'(pred_det + 5'd1));
                    end
                D_DN_FINAL_WAIT:
                    if (t >= cfg_settle)
                    begin
                        r.det_action = ACT_RAILS_OFF;
                        enter_det(D_DN_DONE);
                    end
                default: ;
            endcase

            // then the readiness sequencer
            rdy_ms = ms_bump(rdy_ms);
            case (pred_rdy)
                R_COOLING:
                begin
                    r.cool_action = COOL_START;
                    if (ok)
                        pred_rdy = R_COOLING_WAIT;
                end
                R_COOLING_WAIT:
                    if (int'(temp) <= int'(cfg_target) * 10)
                        pred_rdy = R_DETECTOR;
                R_DETECTOR:
                begin
                    enter_det(D_RAILS);
                    pred_rdy = R_DETECTOR_WAIT;
                end
                R_DETECTOR_WAIT:
                    if (pred_det == D_UP_DONE)
                        pred_rdy = R_COMPLETE;
                R_DET_SHUTDOWN:
                begin
                    enter_det(D_DN50);
                    pred_rdy = R_DET_SHUTDOWN_WAIT;
                end
                R_DET_SHUTDOWN_WAIT:
                    if (pred_det == D_DN_DONE)
                        pred_rdy = R_COOL_SHUTDOWN;
                R_COOL_SHUTDOWN:
                begin
                    r.cool_action = COOL_STOP;
                    if (ok)
                    begin
                        pred_rdy = R_COOL_SHUTDOWN_WAIT;
                        rdy_ms   = '0;
                    end
                end
                R_COOL_SHUTDOWN_WAIT:
                    if (rdy_ms >= cfg_stop_wait)
                        pred_rdy = R_INCOMPLETE;
                default: ;
            endcase
        end
        else if (op == OP_READY)
        begin
            if (req != ready_req_seen)
            begin
                pred_rdy       = req ? R_COOLING : R_DET_SHUTDOWN;
                ready_req_seen = req;
            end
        end
        else if (op == OP_DIRECT)
        begin
            if (req != direct_req_seen)
            begin
                enter_det(req ? D_RAILS : D_DN50);
                direct_req_seen = req;
            end
        end

        r.bias_now    = bias_level;
        r.det_phase   = pred_det;
        r.rdy_phase   = pred_rdy;
        r.complete    = (pred_rdy == R_COMPLETE);
        r.powering_up = (pred_det >= D_RAILS) && (pred_det <= D_UP58);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Prediction on input accept, comparison on result accept
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        seq_result_t want;
        if (rst_n && s_tvalid && s_tready)
            expected_q.push_back(sequence_step(s_tuser, s_tdata[0], s_tdata[1],
                                               s_tdata[13:2]));
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result item with no expected item pending");
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("detector_action", want.det_action,  m_tdata[2:0]);
                check_field("bias_step_volts", want.step_volts,  m_tdata[8:3]);
                check_field("bias_now_volts",  want.bias_now,    m_tdata[14:9]);
                check_field("cooler_action",   want.cool_action, m_tdata[16:15]);
                check_field("detector_phase",  want.det_phase,   m_tdata[21:17]);
                check_field("readiness_phase", want.rdy_phase,   m_tdata[25:22]);
                check_field("complete_flag",   want.complete,    m_tdata[26]);
                check_field("powering_up",     want.powering_up, m_tdata[27]);
            end
        end
    end

    // Result-side stall pattern, re-chosen every stretch of cycles
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 80);
        end
        stall_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ((stall_left % 4) != 0);
            default: m_tready <= (stall_left % 16) >= 8;
        endcase
    end

    // ------------------------------------------------------------------
    // Drivers (called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic req, input logic ok,
                             input logic [11:0] temp);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {2'b00, temp, ok, req};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        s_tvalid = 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_TARGET_TEMP: cfg_target    = value[8:0];
            CFG_STEP_DELAY:  cfg_step      = value;
            CFG_RAIL_SETTLE: cfg_rail      = value;
            CFG_BIAS_SETTLE: cfg_settle    = value;
            CFG_COOLER_WAIT: cfg_stop_wait = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Registers change only with no item in flight
    task automatic program_registers(input logic [8:0] target, input logic [15:0] step,
                                     input logic [15:0] rail, input logic [15:0] settle,
                                     input logic [15:0] stop_wait);
        wait_results_drained();
        write_register(CFG_TARGET_TEMP, {7'd0, target});
        write_register(CFG_STEP_DELAY,  step);
        write_register(CFG_RAIL_SETTLE, rail);
        write_register(CFG_BIAS_SETTLE, settle);
        write_register(CFG_COOLER_WAIT, stop_wait);
    endtask

    function automatic logic [15:0] pick_wait();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(5, 20));
        return 16'($urandom_range(0, 4));
    endfunction

    // Mostly ticks; commands mostly toggle the request so sequences get deep
    task automatic send_random_item();
        int          pick;
        int          goal;
        logic        settled;
        logic [1:0]  op;
        logic        req;
        logic        ok;
        logic [11:0] temp;
        pick    = $urandom_range(0, 99);
        goal    = int'(cfg_target) * 10;
        settled = pred_rdy inside {R_IDLE, R_COMPLETE, R_INCOMPLETE};
        req     = $urandom_range(0, 1);
        ok      = ($urandom_range(0, 3) != 0);
        op      = OP_TICK;
        if (pick < (settled ? 30 : 2))
        begin
            op = OP_READY;
            if (pick % 5 != 0)
                req = ~ready_req_seen;
        end
        else if (pick < (settled ? 33 : 5))
        begin
            op = OP_DIRECT;
            if (pick % 3 != 0)
                req = ~direct_req_seen;
        end
        else if (pick == 99)
            op = OP_RESERVED;
        // temperatures around the cooler target, plus both ends
        case ($urandom_range(0, 5))
            0:       temp = 12'd0;
            1:       temp = 12'hFFF;
            2:       temp = 12'(goal);
            3:       temp = (goal >= 4095) ? 12'hFFF : 12'(goal + 1);
            4:       temp = (goal == 0) ? 12'd0 : 12'(goal - 1);
            default: temp = 12'($urandom);
        endcase
        send_item(op, req, ok, temp);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_power_cycle();
        // reserved opcode with every data bit set: state only
        send_item(OP_RESERVED, 1'b1, 1'b1, 12'hFFF);
        // direct power-up, one tick, then direct power-down mid-sequence
        send_item(OP_DIRECT, 1'b1, 1'b0, 12'h000);
        send_item(OP_TICK, 1'b0, 1'b1, 12'h555);
        send_item(OP_DIRECT, 1'b0, 1'b0, 12'hAAA);
        program_registers(9'd400, 16'd0, 16'd0, 16'd0, 16'd0);
        // readiness: cooler refuses once, then cools to exactly the target
        send_item(OP_READY, 1'b1, 1'b0, 12'h000);
        send_item(OP_TICK, 1'b0, 1'b0, 12'hFFF);
        send_item(OP_TICK, 1'b0, 1'b1, 12'd4001);
        send_item(OP_TICK, 1'b1, 1'b0, 12'd4000);
        // full power-up with zero waits
        repeat (16) send_item(OP_TICK, 1'b0, 1'b1, 12'($urandom));
        // low power from complete
        send_item(OP_READY, 1'b0, 1'b1, 12'h000);
        repeat (2) send_item(OP_TICK, 1'b1, 1'b1, 12'($urandom));
    endtask

    task automatic test_long_waits();
        // largest waits never expire here; lowest target needs 0 dK
        program_registers(9'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (50) send_random_item();
    endtask

    task automatic test_random_sequencing();
        int phase_no;
        for (phase_no = 0; phase_no < 6; phase_no++)
        begin
            case (phase_no)
                0:       program_registers(9'd80, 16'd1, 16'd3, 16'd2, 16'd5);
                1:       program_registers(9'd400, 16'd0, 16'd0, 16'd0, 16'd0);
                default: program_registers(9'($urandom_range(0, 400)), pick_wait(),
                                           pick_wait(), pick_wait(), pick_wait());
            endcase
            repeat (125)
            begin
                send_random_item();
                // occasional hold-off until the result side has caught up
                if ($urandom_range(0, 99) == 0)
                    wait_results_drained();
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_power_cycle();
        test_long_waits();
        test_random_sequencing();

        wait_results_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dps_pkg.sv
rtl/detector_power_sequencer.sv
verif/tb.sv
